### hw/rtl/mms_pkg.sv
package mms_pkg;

  // field widths
  localparam int DX_W       = 16;
  localparam int BTN_W      = 3;
  localparam int SENS_W     = 16;
  localparam int ACC_W      = 20;
  localparam int REM_W      = 17;
  localparam int MAG_W      = 19;
  localparam int AMT_W      = 20;
  localparam int KIND_W     = 2;
  localparam int SRC_W      = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // buttons that produce events (all three are still tracked)
  localparam int BUTTON_COUNT = 3;

  // divider steps, one quotient bit each
  localparam int DIV_STEPS = MAG_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  // event slots: buttons first, then x, then y
  localparam int EV_SLOTS = BTN_W + 2;
  localparam int SLOT_X   = BTN_W;
  localparam int SLOT_Y   = BTN_W + 1;
  localparam int SLOT_W   = $clog2(EV_SLOTS);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HSENS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VSENS  = 2'd2;

  // register reset values
  localparam logic              ENABLE_RST = 1'b0;
  localparam logic [SENS_W-1:0] HSENS_RST  = 16'd8;
  localparam logic [SENS_W-1:0] VSENS_RST  = 16'd16;

  // event sources
  localparam logic [SRC_W-1:0] SRC_X       = 3'd0;
  localparam logic [SRC_W-1:0] SRC_Y       = 3'd1;
  localparam logic [SRC_W-1:0] SRC_BUTTON0 = 3'd2;

  typedef enum logic [KIND_W-1:0] {
    KIND_DOWN = 2'd0,
    KIND_UP   = 2'd1,
    KIND_MOVE = 2'd2
  } kind_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic commit;
    logic emit;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic enabled;
    logic pend_any;
    logic pend_last;
    logic out_free;
  } dp_stat_t;

endpackage

### hw/rtl/mms_in_if.sv
interface mms_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [mms_pkg::DX_W-1:0]      raw_dx;
  logic signed [mms_pkg::DX_W-1:0]      raw_dy;
  logic        [mms_pkg::BTN_W-1:0]     button_mask;

  modport source (output valid, raw_dx, raw_dy, button_mask, input ready);
  modport sink   (input valid, raw_dx, raw_dy, button_mask, output ready);
endinterface

### hw/rtl/mms_out_if.sv
interface mms_out_if;
  logic                                 valid;
  logic                                 ready;
  logic        [mms_pkg::KIND_W-1:0]    event_kind;
  logic        [mms_pkg::SRC_W-1:0]     event_source;
  logic signed [mms_pkg::AMT_W-1:0]     move_amount;
  logic                                 last_of_poll;

  modport source (output valid, event_kind, event_source, move_amount, last_of_poll,
                  input ready);
  modport sink   (input valid, event_kind, event_source, move_amount, last_of_poll,
                  output ready);
endinterface

### hw/rtl/mms_div.sv
module mms_div (
  input  logic                                clk,
  input  logic                                start,
  input  logic                                step,
  input  logic signed [mms_pkg::ACC_W-1:0]    dividend,
  input  logic        [mms_pkg::SENS_W-1:0]   divisor,
  output logic signed [mms_pkg::AMT_W-1:0]    quot,
  output logic signed [mms_pkg::REM_W-1:0]    rem
);

  logic                          neg_r;
  logic [mms_pkg::MAG_W-1:0]     mag_r;
  logic [mms_pkg::SENS_W-1:0]    part_r;
  logic [mms_pkg::SENS_W-1:0]    dsor_r;

  logic [mms_pkg::ACC_W-1:0]     abs_val;
  logic [mms_pkg::SENS_W:0]      trial;
  logic [mms_pkg::SENS_W+1:0]    diff;
  logic                          ge;
  logic [mms_pkg::AMT_W-1:0]     qmag;
  logic [mms_pkg::REM_W-1:0]     rmag;

  // magnitude of the dividend and one restoring step
  always_comb begin
    abs_val = dividend[mms_pkg::ACC_W-1] ? (~dividend + 1'b1) : dividend;
    trial   = {part_r, mag_r[mms_pkg::MAG_W-1]};
    diff    = {1'b0, trial} - {2'b00, dsor_r};
    ge      = ~diff[mms_pkg::SENS_W+1];
  end

  // quotient bits shift in from the bottom as dividend bits leave the top
  always_ff @(posedge clk) begin
    if (start) begin
      neg_r  <= dividend[mms_pkg::ACC_W-1];
      mag_r  <= abs_val[mms_pkg::MAG_W-1:0];
      part_r <= '0;
      dsor_r <= divisor;
    end else if (step) begin
      mag_r  <= {mag_r[mms_pkg::MAG_W-2:0], ge};
      part_r <= ge ? diff[mms_pkg::SENS_W-1:0] : trial[mms_pkg::SENS_W-1:0];
    end
  end

  // truncation toward zero: both results take the dividend's sign
  always_comb begin
    qmag = {1'b0, mag_r};
    rmag = {1'b0, part_r};
    quot = neg_r ? $signed(~qmag + 1'b1) : $signed(qmag);
    rem  = neg_r ? $signed(~rmag + 1'b1) : $signed(rmag);
  end

endmodule

### hw/rtl/mms_ctrl.sv
module mms_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  mms_pkg::dp_stat_t     stat,
  output mms_pkg::ctrl_cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_FIN,
    S_EMIT
  } state_t;

  state_t                      state_r, state_nxt;
  logic [mms_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;

  // next state and datapath commands
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && stat.enabled) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == mms_pkg::CNT_W'(mms_pkg::DIV_STEPS - 1)) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.commit = 1'b1;
        state_nxt  = S_EMIT;
      end
      S_EMIT: begin
        if (!stat.pend_any) begin
          state_nxt = S_IDLE;
        end else if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.pend_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

### hw/rtl/mms_dp.sv
module mms_dp #(
  parameter int BUTTON_COUNT = mms_pkg::BUTTON_COUNT
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic        [mms_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic        [mms_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic signed [mms_pkg::DX_W-1:0]       in_dx,
  input  logic signed [mms_pkg::DX_W-1:0]       in_dy,
  input  logic        [mms_pkg::BTN_W-1:0]      in_buttons,
  input  mms_pkg::ctrl_cmd_t                    cmd,
  output mms_pkg::dp_stat_t                     stat,
  input  logic                                  out_ready,
  output logic                                  out_valid,
  output logic        [mms_pkg::KIND_W-1:0]     out_kind,
  output logic        [mms_pkg::SRC_W-1:0]      out_src,
  output logic signed [mms_pkg::AMT_W-1:0]      out_amount,
  output logic                                  out_last
);

  // configuration
  logic                           enabled_r;
  logic [mms_pkg::SENS_W-1:0]     hsens_r;
  logic [mms_pkg::SENS_W-1:0]     vsens_r;

  // poll state
  logic [mms_pkg::BTN_W-1:0]      prev_r;
  logic signed [mms_pkg::REM_W-1:0] rem_x_r;
  logic signed [mms_pkg::REM_W-1:0] rem_y_r;
  logic [mms_pkg::EV_SLOTS-1:0]   pend_r;

  // output register
  logic                           out_valid_r;
  mms_pkg::kind_t                 out_kind_r;
  logic [mms_pkg::SRC_W-1:0]      out_src_r;
  logic signed [mms_pkg::AMT_W-1:0] out_amount_r;
  logic                           out_last_r;

  logic [mms_pkg::SENS_W-1:0]     hdiv, vdiv;
  logic signed [mms_pkg::ACC_W-1:0] acc_x, acc_y;
  logic signed [mms_pkg::AMT_W-1:0] qx, qy;
  logic signed [mms_pkg::REM_W-1:0] rx, ry;
  logic [mms_pkg::BTN_W-1:0]      btn_live;
  logic [mms_pkg::BTN_W-1:0]      btn_chg;
  logic [mms_pkg::SLOT_W-1:0]     sel;
  logic [mms_pkg::EV_SLOTS-1:0]   sel_oh;
  logic [mms_pkg::EV_SLOTS-1:0]   pend_left;
  logic                           out_free;

  // sensitivity of zero acts as one
  always_comb begin
    hdiv = (hsens_r == '0) ? mms_pkg::SENS_W'(1) : hsens_r;
    vdiv = (vsens_r == '0) ? mms_pkg::SENS_W'(1) : vsens_r;
  end

  // remainder plus raw motion times eight
  always_comb begin
    acc_x = $signed({{(mms_pkg::ACC_W-mms_pkg::REM_W){rem_x_r[mms_pkg::REM_W-1]}}, rem_x_r})
          + $signed({in_dx[mms_pkg::DX_W-1], in_dx, 3'b000});
    acc_y = $signed({{(mms_pkg::ACC_W-mms_pkg::REM_W){rem_y_r[mms_pkg::REM_W-1]}}, rem_y_r})
          + $signed({in_dy[mms_pkg::DX_W-1], in_dy, 3'b000});
  end

  mms_div u_div_x (
    .clk      (clk),
    .start    (cmd.load),
    .step     (cmd.step),
    .dividend (acc_x),
    .divisor  (hdiv),
    .quot     (qx),
    .rem      (rx)
  );

  mms_div u_div_y (
    .clk      (clk),
    .start    (cmd.load),
    .step     (cmd.step),
    .dividend (acc_y),
    .divisor  (vdiv),
    .quot     (qy),
    .rem      (ry)
  );

  // buttons that report events
  always_comb begin
    for (int i = 0; i < mms_pkg::BTN_W; i++) begin
      btn_live[i] = (i < BUTTON_COUNT);
    end
    btn_chg = (in_buttons ^ prev_r) & btn_live;
  end

  // lowest pending slot goes out first
  always_comb begin
    sel = '0;
    for (int i = mms_pkg::EV_SLOTS - 1; i >= 0; i--) begin
      if (pend_r[i]) begin
        sel = mms_pkg::SLOT_W'(i);
      end
    end
    sel_oh    = pend_r & (~pend_r + 1'b1);
    pend_left = pend_r & ~sel_oh;
    out_free  = ~out_valid_r | out_ready;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r <= mms_pkg::ENABLE_RST;
      hsens_r   <= mms_pkg::HSENS_RST;
      vsens_r   <= mms_pkg::VSENS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        mms_pkg::CFG_ENABLE: enabled_r <= cfg_data[0];
        mms_pkg::CFG_HSENS:  hsens_r   <= cfg_data[mms_pkg::SENS_W-1:0];
        mms_pkg::CFG_VSENS:  vsens_r   <= cfg_data[mms_pkg::SENS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // button history, remainders and pending events
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= '0;
      rem_x_r <= '0;
      rem_y_r <= '0;
      pend_r  <= '0;
    end else begin
      if (cmd.load) begin
        prev_r <= in_buttons;
        pend_r <= {2'b00, btn_chg};
      end else if (cmd.commit) begin
        rem_x_r               <= rx;
        rem_y_r               <= ry;
        pend_r[mms_pkg::SLOT_X] <= (qx != '0);
        pend_r[mms_pkg::SLOT_Y] <= (qy != '0);
      end else if (cmd.emit) begin
        pend_r <= pend_left;
      end
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_last_r <= (pend_left == '0);
      if (sel == mms_pkg::SLOT_W'(mms_pkg::SLOT_X)) begin
        out_kind_r   <= mms_pkg::KIND_MOVE;
        out_src_r    <= mms_pkg::SRC_X;
        out_amount_r <= qx;
      end else if (sel == mms_pkg::SLOT_W'(mms_pkg::SLOT_Y)) begin
        out_kind_r   <= mms_pkg::KIND_MOVE;
        out_src_r    <= mms_pkg::SRC_Y;
        out_amount_r <= qy;
      end else begin
        out_kind_r   <= prev_r[sel[$clog2(mms_pkg::BTN_W)-1:0]] ? mms_pkg::KIND_DOWN
                                                                 : mms_pkg::KIND_UP;
        out_src_r    <= mms_pkg::SRC_BUTTON0 + mms_pkg::SRC_W'(sel);
        out_amount_r <= '0;
      end
    end
  end

  always_comb begin
    stat.enabled   = enabled_r;
    stat.pend_any  = (pend_r != '0);
    stat.pend_last = (pend_r != '0) && (pend_left == '0);
    stat.out_free  = out_free;
    out_valid      = out_valid_r;
    out_kind       = out_kind_r;
    out_src        = out_src_r;
    out_amount     = out_amount_r;
    out_last       = out_last_r;
  end

`ifndef ASSERT_OFF
  a_emit_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (pend_r != '0) && (!out_valid_r || out_ready))
    else $error("event issued without a pending slot or free output");

  a_commit_moves: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> (pend_r[mms_pkg::SLOT_X] == (qx != '0))
                && (pend_r[mms_pkg::SLOT_Y] == (qy != '0)))
    else $error("motion events do not match quotients");

  a_move_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == mms_pkg::KIND_MOVE) |-> (out_amount_r != '0))
    else $error("motion event with zero amount");

  a_button_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r != mms_pkg::KIND_MOVE) |->
      (out_amount_r == '0) && (out_src_r != mms_pkg::SRC_X) && (out_src_r != mms_pkg::SRC_Y))
    else $error("button event with motion payload");
`endif

endmodule

### hw/rtl/mouse_motion_scaler_events.sv
// channel   dir  handshake      payload
// in_bus    in   valid/ready    raw_dx, raw_dy, button_mask
// out_bus   out  valid/ready    event_kind, event_source, move_amount, last_of_poll
// cfg_*     in   cfg_we only    cfg_index, cfg_data
//
// a poll is taken while the controller is idle; with the mouse disabled it is dropped at once
// an enabled poll runs 19 divider steps (one quotient bit per cycle, x and y
// side by side), then a commit state stores the remainders, then the events
// issue one at a time, events 0 to 5
// the output register lets a finished event wait while the next poll is taken
// a stalled output holds event issue; reset is synchronous, active low
module mouse_motion_scaler_events #(
  parameter int BUTTON_COUNT = mms_pkg::BUTTON_COUNT
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  mms_in_if.sink                                in_bus,
  mms_out_if.source                             out_bus,
  input  logic                                  cfg_we,
  input  logic        [mms_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic        [mms_pkg::CFG_DATA_W-1:0] cfg_data
);

  mms_pkg::ctrl_cmd_t  cmd;
  mms_pkg::dp_stat_t   stat;

  mms_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ready (in_bus.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mms_dp #(
    .BUTTON_COUNT (BUTTON_COUNT)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_dx      (in_bus.raw_dx),
    .in_dy      (in_bus.raw_dy),
    .in_buttons (in_bus.button_mask),
    .cmd        (cmd),
    .stat       (stat),
    .out_ready  (out_bus.ready),
    .out_valid  (out_bus.valid),
    .out_kind   (out_bus.event_kind),
    .out_src    (out_bus.event_source),
    .out_amount (out_bus.move_amount),
    .out_last   (out_bus.last_of_poll)
  );

endmodule
